FILE: rtl/sent_pkg.sv
// ----------------------------------------------------------------------------
// SENT capture batcher package
// Shared codes, widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
package sent_pkg;

  // Input mode codes.
  localparam logic [2:0] MODE_EDGE     = 3'd0;
  localparam logic [2:0] MODE_OVERFLOW = 3'd1;
  localparam logic [2:0] MODE_POLL     = 3'd2;
  localparam logic [2:0] MODE_START    = 3'd3;
  localparam logic [2:0] MODE_STOP     = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_VALID       = 2'd0;
  localparam logic [1:0] ST_EMPTY       = 2'd1;
  localparam logic [1:0] ST_SMALL       = 2'd2;
  localparam logic [1:0] ST_NOT_RUNNING = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PERIOD = 3'd0;
  localparam logic [2:0] CFG_MUL    = 3'd1;
  localparam logic [2:0] CFG_BATCH  = 3'd2;
  localparam logic [2:0] CFG_DEPTH  = 3'd3;
  localparam logic [2:0] CFG_SYNC   = 3'd4;

  // Fraction width of the Q12 conversion.
  localparam int FRAC_BITS = 12;

  // One classified command waiting for the back end.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] cap;
    logic [4:0]  capacity;
  } cmd_t;

endpackage

FILE: rtl/sent_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sent_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sent_front.sv
// ----------------------------------------------------------------------------
// SENT capture front end
// Accepts input transfers, drops unknown modes and queues the rest in a
// two-entry command FIFO for the back end.
// ----------------------------------------------------------------------------
module sent_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic [15:0]         captured_count,
  input  logic [4:0]          capacity,
  output logic                cmd_valid,
  output sent_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  sent_pkg::cmd_t fifo [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;
  logic           known;
  logic           push;

  // Classify the mode; unknown codes are accepted and discarded.
  always_comb begin
    unique case (mode)
      sent_pkg::MODE_EDGE, sent_pkg::MODE_OVERFLOW, sent_pkg::MODE_POLL,
      sent_pkg::MODE_START, sent_pkg::MODE_STOP: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready && known;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = fifo[rptr];

  // Command FIFO storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= '{kind: mode, cap: captured_count, capacity: capacity};
    end
  end

  // FIFO pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

FILE: rtl/sent_back.sv
// ----------------------------------------------------------------------------
// SENT capture back end
// Executes commands: keeps the tick base, converts edge intervals to
// microseconds, builds batches in place in the ring memory and streams
// polled batches to the output register.
// ----------------------------------------------------------------------------
module sent_back #(
  parameter int MAX_BATCH = 16,
  parameter int MAX_QUEUE = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           cmd_valid,
  input  sent_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [31:0]    timestamp_us,
  output logic [4:0]     batch_len,
  output logic           last,
  output logic [31:0]    dropped_count
);

  localparam int CW   = $clog2(MAX_BATCH + 1);
  localparam int IW   = $clog2(MAX_BATCH);
  localparam int SW   = $clog2(MAX_QUEUE);
  localparam int EW   = (SW + 1 > 4) ? SW + 1 : 4;
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int DEPTH = MAX_QUEUE * MAX_BATCH;
  localparam int AW   = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_SYNC  = 4'd3;
  localparam logic [3:0] S_APP   = 4'd4;
  localparam logic [3:0] S_PUSH  = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_PLD   = 4'd8;

  // Configuration registers.
  logic [15:0] period_m1;
  logic [31:0] mul;
  logic [4:0]  bsize;
  logic [3:0]  qdepth;
  logic [31:0] sync_min;

  // Block state.
  logic [3:0]    state;
  logic          running;
  logic [63:0]   tick_base;
  logic [63:0]   last_tick;
  logic [31:0]   last_time;
  logic [11:0]   frac;
  logic [CW-1:0] count;
  logic [31:0]   tail;
  logic [SW-1:0] wslot;
  logic [SW-1:0] rslot;
  logic [31:0]   drop_total;
  logic [CW-1:0] counts [MAX_QUEUE];

  // Edge pipeline and poll registers.
  logic [63:0]   now;
  logic [63:0]   prod;
  logic [31:0]   prev;
  logic          sync_hit;
  logic [IW-1:0] pidx;
  logic [CW-1:0] pn;
  logic [1:0]    pend_status;
  logic [CW-1:0] pend_count;

  // Combinational helpers.
  logic [31:0]   delta;
  logic [31:0]   mul_eff;
  logic [63:0]   scaled;
  logic [31:0]   step;
  logic          app_ok;
  logic          push_ok;
  logic [SW-1:0] wnext;
  logic          ring_full;
  logic          out_free;
  logic          out_load;
  logic          start_ok;
  logic [CW-1:0] head_n;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // Next ring slot under the clamped depth in use.
  function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] s,
                                               input logic [3:0] depth);
    logic [EW-1:0] eff;
    logic [EW-1:0] n;
    if (depth == 4'd0) begin
      eff = EW'(1);
    end else if (EW'(depth) > EW'(MAX_QUEUE)) begin
      eff = EW'(MAX_QUEUE);
    end else begin
      eff = EW'(depth);
    end
    n = EW'(s) + EW'(1);
    return (n >= eff) ? '0 : n[SW-1:0];
  endfunction

  // Ring memory address of one entry of one slot.
  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s,
                                            input logic [IW-1:0] i);
    return AW'(s) * AW'(MAX_BATCH) + AW'(i);
  endfunction

  assign delta     = now[31:0] - last_tick[31:0];
  assign mul_eff   = (mul == 32'd0) ? 32'd1 : mul;
  assign scaled    = prod + {52'd0, frac};
  assign step      = scaled[sent_pkg::FRAC_BITS +: 32];
  assign app_ok    = (CMPW'(count) < CMPW'(bsize)) && (count < CW'(MAX_BATCH));
  assign push_ok   = (CMPW'(count) >= CMPW'(bsize)) && (count != '0);
  assign wnext     = slot_after(wslot, qdepth);
  assign ring_full = (wnext == rslot);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_EMIT) || (state == S_PLD)) && out_free;
  assign head_n    = counts[rslot];
  assign start_ok  = (bsize != 5'd0) && (CMPW'(bsize) <= CMPW'(MAX_BATCH)) &&
                     (qdepth != 4'd0) && (EW'(qdepth) <= EW'(MAX_QUEUE));
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  // Ring memory write and read selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(wslot, '0);
    ram_wdata = tail;
    unique case (state)
      S_SYNC: begin
        ram_we    = sync_hit;
        ram_wdata = prev;
      end
      S_APP: begin
        ram_we    = app_ok;
        ram_waddr = addr_of(wslot, count[IW-1:0]);
        ram_wdata = last_time;
      end
      S_PUSH: begin
        ram_we    = push_ok && !ring_full;
        ram_waddr = addr_of(wnext, '0);
      end
      default: ram_we = 1'b0;
    endcase
    ram_re    = (state == S_PRD);
    ram_raddr = addr_of(rslot, pidx);
  end

  sent_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Batch counts per slot.
  always_ff @(posedge clk) begin
    if (state == S_PUSH && push_ok && !ring_full) begin
      counts[wslot] <= count;
    end
  end

  // Edge pipeline and poll payload registers.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      now <= tick_base + {48'd0, cmd.cap};
    end
    if (state == S_DELTA) begin
      prod <= 64'(delta) * 64'(mul_eff);
    end
    if (state == S_CONV) begin
      prev     <= last_time;
      sync_hit <= (sync_min != 32'd0) && (count != '0) && (step >= sync_min);
    end
  end

  // Sequencer, state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      period_m1   <= 16'hFFFF;
      mul         <= 32'd85;
      bsize       <= 5'd16;
      qdepth      <= 4'd8;
      sync_min    <= 32'd0;
      running     <= 1'b0;
      tick_base   <= '0;
      last_tick   <= '0;
      last_time   <= '0;
      frac        <= '0;
      count       <= '0;
      tail        <= '0;
      wslot       <= '0;
      rslot       <= '0;
      drop_total  <= '0;
      pidx        <= '0;
      pn          <= '0;
      pend_status <= sent_pkg::ST_EMPTY;
      pend_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A new result loads the output register; a transfer empties it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              sent_pkg::MODE_EDGE: begin
                if (running) begin
                  state <= S_DELTA;
                end
              end
              sent_pkg::MODE_OVERFLOW: begin
                if (running) begin
                  tick_base <= tick_base + {48'd0, period_m1} + 64'd1;
                end
              end
              sent_pkg::MODE_START: begin
                if (start_ok) begin
                  wslot      <= '0;
                  rslot      <= '0;
                  drop_total <= '0;
                  tick_base  <= '0;
                  last_tick  <= '0;
                  last_time  <= '0;
                  frac       <= '0;
                  count      <= '0;
                  running    <= 1'b1;
                end
              end
              sent_pkg::MODE_STOP: running <= 1'b0;
              sent_pkg::MODE_POLL: begin
                pend_count <= '0;
                if (!running) begin
                  pend_status <= sent_pkg::ST_NOT_RUNNING;
                  state       <= S_EMIT;
                end else if (rslot == wslot) begin
                  pend_status <= sent_pkg::ST_EMPTY;
                  state       <= S_EMIT;
                end else if (CMPW'(cmd.capacity) < CMPW'(head_n)) begin
                  pend_status <= sent_pkg::ST_SMALL;
                  pend_count  <= head_n;
                  state       <= S_EMIT;
                end else begin
                  pn    <= head_n;
                  pidx  <= '0;
                  state <= S_PRD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DELTA: begin
          last_tick <= now;
          state     <= S_CONV;
        end
        S_CONV: begin
          frac      <= scaled[sent_pkg::FRAC_BITS-1:0];
          last_time <= last_time + step;
          state     <= S_SYNC;
        end
        S_SYNC: begin
          if (sync_hit) begin
            count <= CW'(1);
            tail  <= prev;
          end
          state <= S_APP;
        end
        S_APP: begin
          if (app_ok) begin
            count <= count + CW'(1);
            tail  <= last_time;
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            if (ring_full) begin
              drop_total <= drop_total + 32'd1;
              count      <= '0;
            end else begin
              wslot <= wnext;
              count <= CW'(1);
            end
          end
          state <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            status        <= pend_status;
            timestamp_us  <= '0;
            batch_len     <= 5'(pend_count);
            last          <= 1'b1;
            dropped_count <= drop_total;
            state         <= S_IDLE;
          end
        end
        S_PRD: state <= S_PLD;
        S_PLD: begin
          if (out_free) begin
            status        <= sent_pkg::ST_VALID;
            timestamp_us  <= ram_rdata;
            batch_len     <= 5'(pn);
            last          <= (CW'(pidx) + CW'(1) == pn);
            dropped_count <= drop_total;
            if (CW'(pidx) + CW'(1) == pn) begin
              rslot <= slot_after(rslot, qdepth);
              state <= S_IDLE;
            end else begin
              pidx  <= pidx + IW'(1);
              state <= S_PRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // Configuration writes must come only while idle; the block never checks.
      if (cfg_we) begin
        unique case (cfg_index)
          sent_pkg::CFG_PERIOD: period_m1 <= cfg_data[15:0];
          sent_pkg::CFG_MUL:    mul       <= cfg_data;
          sent_pkg::CFG_BATCH: begin
            bsize <= cfg_data[4:0];
            count <= '0;
          end
          sent_pkg::CFG_DEPTH:  qdepth    <= cfg_data[3:0];
          sent_pkg::CFG_SYNC: begin
            sync_min <= cfg_data;
            count    <= '0;
          end
          default: period_m1 <= period_m1;
        endcase
      end
    end
  end

endmodule

FILE: rtl/sent_edge_capture_batcher.sv
// ----------------------------------------------------------------------------
// SENT edge capture batcher
// Top level: command front end, two-entry command FIFO and executing back end.
// ----------------------------------------------------------------------------
// Commands are executed one at a time by the back-end sequencer. An overflow,
// start or stop is handled in the idle state; an edge passes the tick sum, a
// 32x32 multiply, the fraction add and up to three ring memory writes, and a
// poll that hands out a batch of n timestamps passes the read and load states
// once per timestamp, as each is one registered read of the ring memory's
// single read port. Error and empty polls give one result. While its FIFO has
// room, the front end keeps accepting input transfers while the back end works
// or the output register waits. There is no clearing pass after reset.
module sent_edge_capture_batcher #(
  parameter int MAX_BATCH = 16,
  parameter int MAX_QUEUE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] captured_count,
  input  logic [4:0]  capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] timestamp_us,
  output logic [4:0]  batch_len,
  output logic        last,
  output logic [31:0] dropped_count
);

  logic           cmd_valid;
  logic           cmd_pop;
  sent_pkg::cmd_t cmd;

  sent_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .captured_count (captured_count),
    .capacity       (capacity),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  sent_back #(
    .MAX_BATCH (MAX_BATCH),
    .MAX_QUEUE (MAX_QUEUE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .timestamp_us  (timestamp_us),
    .batch_len     (batch_len),
    .last          (last),
    .dropped_count (dropped_count)
  );

endmodule

FILE: rtl/sent_checker.sv
// ----------------------------------------------------------------------------
// SENT batcher port checker
// Checks result rules visible on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module sent_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] timestamp_us,
  input logic [4:0]  batch_len,
  input logic        last
);

  // A stalled result transfer holds its timestamp.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(timestamp_us))
    else $error("stalled result changed");

  // An error or empty answer is always the final result of its poll.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != sent_pkg::ST_VALID) |-> last)
    else $error("error result not marked last");

  // Error answers carry no timestamp.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != sent_pkg::ST_VALID) |-> timestamp_us == 32'd0)
    else $error("error result carries a timestamp");

  // Empty and not-running answers report no batch.
  a_no_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == sent_pkg::ST_EMPTY) ||
                  (status == sent_pkg::ST_NOT_RUNNING)) |-> batch_len == 5'd0)
    else $error("empty answer reports a batch size");

endmodule

bind sent_edge_capture_batcher sent_checker u_sent_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .timestamp_us (timestamp_us),
  .batch_len    (batch_len),
  .last         (last)
);

FILE: tb/sent_edge_capture_batcher_tb.sv
// ----------------------------------------------------------------------------
// SENT edge capture batcher testbench
// Drives edge, overflow, poll, start and stop commands through the input
// channel, predicts every poll result with a local model of the batcher, and
// compares each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sent_edge_capture_batcher_tb;

  localparam int MAXB = 16;
  localparam int MAXQ = 8;

  // One predicted result of a poll.
  typedef struct {
    logic [1:0]  st;
    logic [31:0] ts;
    logic [4:0]  cnt;
    logic        lst;
    logic [31:0] drops;
  } stamp_res_t;

  // One row of the directed table; chk set means the first result is typed in.
  typedef struct {
    logic [2:0]  md;
    logic [15:0] cap;
    logic [4:0]  capy;
    logic        chk;
    logic [1:0]  st;
    logic [4:0]  cnt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = '0;
  logic [15:0] captured_count = '0;
  logic [4:0]  capacity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] timestamp_us;
  logic [4:0]  batch_len;
  logic        last;
  logic [31:0] dropped_count;

  // Predictor copy of registers and state.
  logic [15:0] p_period;
  logic [31:0] p_mul;
  logic [4:0]  p_bsize;
  logic [3:0]  p_depth;
  logic [31:0] p_sync;
  logic        p_running;
  logic [63:0] p_tick_base;
  logic [63:0] p_last_tick;
  logic [31:0] p_last_us;
  logic [11:0] p_frac;
  int unsigned p_active;
  logic [31:0] p_act_stamps[MAXB];
  logic [31:0] p_ring[MAXQ][MAXB];
  logic [4:0]  p_ring_cnt[MAXQ];
  int unsigned p_wr;
  int unsigned p_rd;
  logic [31:0] p_drops;

  stamp_res_t expected_stamps[$];
  int errors = 0;
  bit long_hold = 1'b0;
  int unsigned rx_wait = 0;

  sent_edge_capture_batcher dut (.*);

  always #5 clk = ~clk;

  function automatic int unsigned depth_used();
    if (p_depth == 0) return 1;
    if (p_depth > MAXQ) return MAXQ;
    return p_depth;
  endfunction

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1 >= depth_used()) ? 0 : s + 1;
  endfunction

  task automatic predict_reset();
    p_period = 16'hFFFF; p_mul = 32'd85; p_bsize = 5'd16; p_depth = 4'd8;
    p_sync = '0; p_running = 1'b0; p_tick_base = '0; p_last_tick = '0;
    p_last_us = '0; p_frac = '0; p_active = 0; p_wr = 0; p_rd = 0;
    p_drops = '0;
  endtask

  task automatic predict_cfg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      sent_pkg::CFG_PERIOD: p_period = val[15:0];
      sent_pkg::CFG_MUL:    p_mul = val;
      sent_pkg::CFG_BATCH: begin
        p_bsize = val[4:0]; p_active = 0;
      end
      sent_pkg::CFG_DEPTH:  p_depth = val[3:0];
      sent_pkg::CFG_SYNC: begin
        p_sync = val; p_active = 0;
      end
      default: ;
    endcase
  endtask

  task automatic push_active_batch();
    int unsigned nx, n;
    if (p_active == 0) return;
    nx = next_slot(p_wr);
    if (nx == p_rd) begin
      p_drops++;
      p_active = 0;
      return;
    end
    n = (p_active > MAXB) ? MAXB : p_active;
    p_ring_cnt[p_wr] = n[4:0];
    for (int i = 0; i < n; i++) p_ring[p_wr][i] = p_act_stamps[i];
    p_act_stamps[0] = p_act_stamps[n-1];
    p_active = 1;
    p_wr = nx;
  endtask

  task automatic add_expect(logic [1:0] st, logic [31:0] ts, logic [4:0] cnt, logic lst);
    stamp_res_t r;
    r.st = st; r.ts = ts; r.cnt = cnt; r.lst = lst; r.drops = p_drops;
    expected_stamps.push_back(r);
  endtask

  // Advances the local model by one command and queues any poll results.
  task automatic predict_command(logic [2:0] md, logic [15:0] cap, logic [4:0] capy);
    logic [63:0] now, mul, scaled;
    logic [31:0] delta, prev, step;
    int unsigned n;
    case (md)
      sent_pkg::MODE_EDGE: if (p_running) begin
        now = p_tick_base + 64'(cap);
        delta = 32'(now - p_last_tick);
        prev = p_last_us;
        p_last_tick = now;
        mul = (p_mul == 0) ? 64'd1 : 64'(p_mul);
        scaled = 64'(delta) * mul + 64'(p_frac);
        p_frac = scaled[11:0];
        step = scaled[43:12];
        p_last_us = prev + step;
        if (p_sync != 0 && p_active > 0 && step >= p_sync) begin
          p_act_stamps[0] = prev;
          p_active = 1;
        end
        if (p_active < p_bsize && p_active < MAXB) begin
          p_act_stamps[p_active] = p_last_us;
          p_active++;
        end
        if (p_active >= p_bsize) push_active_batch();
      end
      sent_pkg::MODE_OVERFLOW: if (p_running) p_tick_base += 64'(p_period) + 64'd1;
      sent_pkg::MODE_POLL: begin
        if (!p_running) add_expect(sent_pkg::ST_NOT_RUNNING, '0, '0, 1'b1);
        else if (p_rd == p_wr) add_expect(sent_pkg::ST_EMPTY, '0, '0, 1'b1);
        else begin
          n = p_ring_cnt[p_rd];
          if (capy < n) add_expect(sent_pkg::ST_SMALL, '0, n[4:0], 1'b1);
          else begin
            for (int i = 0; i < n; i++)
              add_expect(sent_pkg::ST_VALID, p_ring[p_rd][i], n[4:0], i + 1 == n);
            p_rd = next_slot(p_rd);
          end
        end
      end
      sent_pkg::MODE_START:
        if (p_bsize != 0 && p_bsize <= MAXB && p_depth != 0 && p_depth <= MAXQ) begin
          p_wr = 0; p_rd = 0; p_drops = '0; p_tick_base = '0; p_last_tick = '0;
          p_last_us = '0; p_frac = '0; p_active = 0; p_running = 1'b1;
        end
      sent_pkg::MODE_STOP: p_running = 1'b0;
      default: ;
    endcase
  endtask

  // Register writes wait until every predicted result has arrived and the block has settled.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_cfg(idx, val);
  endtask

  // Waits for all predicted results, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Offers one command and holds it until the transfer; valid stays high
  // when the next command follows with no gap.
  task automatic send_command(logic [2:0] md, logic [15:0] cap, logic [4:0] capy,
                              int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; mode <= md; captured_count <= cap; capacity <= capy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(md, cap, capy);
  endtask

  function automatic int unsigned draw_gap(bit busy);
    return busy ? $urandom_range(0, 10) : 0;
  endfunction

  // Mostly edges and polls, plus overflows, starts, stops and unknown modes.
  task automatic random_item(bit busy);
    int unsigned r;
    logic [2:0] md;
    r = $urandom_range(0, 99);
    if (r < 60) md = sent_pkg::MODE_EDGE;
    else if (r < 72) md = sent_pkg::MODE_OVERFLOW;
    else if (r < 94) md = sent_pkg::MODE_POLL;
    else if (r < 97) md = sent_pkg::MODE_START;
    else if (r < 98) md = sent_pkg::MODE_STOP;
    else md = 3'($urandom_range(5, 7));
    send_command(md, 16'($urandom), 5'($urandom_range(0, 31)), draw_gap(busy));
  endtask

  dir_row_t dir_rows[$];

  // Receiver: draws a random wait per result, plus one long hold-off.
  always @(posedge clk) begin
    int unsigned w;
    if (rst || long_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 10);
      out_ready <= (w == 0);
      rx_wait <= (w == 0) ? 0 : w - 1;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    stamp_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_stamps.size() == 0) begin
        $error("unexpected result: status %0d ts %0h", status, timestamp_us);
        errors++;
      end else begin
        e = expected_stamps.pop_front();
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (timestamp_us !== e.ts) begin
          $error("timestamp_us exp %0h got %0h", e.ts, timestamp_us); errors++;
        end
        if (batch_len !== e.cnt) begin
          $error("batch_len exp %0d got %0d", e.cnt, batch_len); errors++;
        end
        if (last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, last); errors++;
        end
        if (dropped_count !== e.drops) begin
          $error("dropped_count exp %0d got %0d", e.drops, dropped_count); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[sent_edge_capture_batcher] ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    int unsigned nexp;
    predict_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: idle polls, a start, edge extremes, unknown modes, small batches.
    dir_rows = '{
      '{sent_pkg::MODE_POLL,     16'h0000, 5'd16, 1'b1, sent_pkg::ST_NOT_RUNNING, 5'd0},
      '{sent_pkg::MODE_EDGE,     16'hFFFF, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_START,    16'h0000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_POLL,     16'h0000, 5'd31, 1'b1, sent_pkg::ST_EMPTY, 5'd0},
      '{sent_pkg::MODE_EDGE,     16'h0000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_EDGE,     16'hFFFF, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_OVERFLOW, 16'h0000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_EDGE,     16'h0001, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_EDGE,     16'h8000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{3'd5,                    16'h1234, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{3'd7,                    16'hFFFF, 5'd31, 1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_POLL,     16'h0000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_POLL,     16'h0000, 5'd16, 1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_STOP,     16'h0000, 5'd0,  1'b0, sent_pkg::ST_VALID, 5'd0},
      '{sent_pkg::MODE_POLL,     16'hFFFF, 5'd0,  1'b1, sent_pkg::ST_NOT_RUNNING, 5'd0}
    };
    write_reg(sent_pkg::CFG_BATCH, 32'd4);
    foreach (dir_rows[i]) begin
      nexp = expected_stamps.size();
      send_command(dir_rows[i].md, dir_rows[i].cap, dir_rows[i].capy, draw_gap(1'b1));
      if (dir_rows[i].chk && (expected_stamps.size() != nexp + 1 ||
          expected_stamps[nexp].st != dir_rows[i].st ||
          expected_stamps[nexp].cnt != dir_rows[i].cnt)) begin
        $error("directed row %0d: prediction disagrees with table", i);
        errors++;
      end
    end
    wait_drained();

    // Invalid starts: batch size 0 and above the maximum, depth 0 and above.
    write_reg(sent_pkg::CFG_BATCH, 32'd0);
    send_command(sent_pkg::MODE_START, '0, '0, 0);
    send_command(sent_pkg::MODE_POLL, '0, 5'd16, 0);
    write_reg(sent_pkg::CFG_BATCH, 32'd31);
    send_command(sent_pkg::MODE_START, '0, '0, 0);
    write_reg(sent_pkg::CFG_BATCH, 32'd2);
    write_reg(sent_pkg::CFG_DEPTH, 32'd0);
    send_command(sent_pkg::MODE_START, '0, '0, 0);
    write_reg(sent_pkg::CFG_DEPTH, 32'd15);
    send_command(sent_pkg::MODE_START, '0, '0, 0);
    send_command(sent_pkg::MODE_POLL, '0, 5'd16, 0);
    wait_drained();

    // Random phases over a range of settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(sent_pkg::CFG_PERIOD, 32'd0); write_reg(sent_pkg::CFG_MUL, 32'd1);
          write_reg(sent_pkg::CFG_BATCH, 32'd1); write_reg(sent_pkg::CFG_DEPTH, 32'd1);
          write_reg(sent_pkg::CFG_SYNC, 32'd0);
        end
        1: begin
          write_reg(sent_pkg::CFG_PERIOD, 32'd65535);
          write_reg(sent_pkg::CFG_MUL, 32'd4096000000);
          write_reg(sent_pkg::CFG_BATCH, 32'd16); write_reg(sent_pkg::CFG_DEPTH, 32'd8);
          write_reg(sent_pkg::CFG_SYNC, 32'hFFFFFFFF);
        end
        2: begin
          write_reg(sent_pkg::CFG_MUL, 32'd0); write_reg(sent_pkg::CFG_BATCH, 32'd3);
          write_reg(sent_pkg::CFG_DEPTH, 32'd2); write_reg(sent_pkg::CFG_SYNC, 32'd1);
        end
        default: begin
          write_reg(sent_pkg::CFG_PERIOD, 32'($urandom_range(0, 65535)));
          write_reg(sent_pkg::CFG_MUL, ($urandom_range(0, 1) != 0) ? $urandom
                                       : 32'($urandom_range(0, 8192)));
          write_reg(sent_pkg::CFG_BATCH, 32'($urandom_range(2, 6)));
          write_reg(sent_pkg::CFG_DEPTH, 32'($urandom_range(2, 8)));
          write_reg(sent_pkg::CFG_SYNC, ($urandom_range(0, 1) != 0) ? 32'd0
                                        : 32'($urandom_range(1, 4000)));
        end
      endcase
      send_command(sent_pkg::MODE_START, '0, '0, 0);
      if (ph == 4) begin
        // Long receiver hold-off while the sender keeps offering commands.
        fork
          begin
            long_hold = 1'b1;
            repeat (300) @(posedge clk);
            long_hold = 1'b0;
          end
          repeat (20) random_item(1'b0);
        join
      end
      for (int k = 0; k < 12; k++) begin
        random_item(k >= 4);
        // Sender pause until every expected result has arrived.
        if (k == 7) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_stamps.size() != 0) @(posedge clk);
        end
      end
      send_command(sent_pkg::MODE_POLL, '0, 5'd16, 0);
      wait_drained();
    end
    // Large batch size stalls at the maximum; unsupported after start.
    write_reg(sent_pkg::CFG_BATCH, 32'd20);
    repeat (20) random_item(1'b1);
    wait_drained();

    if (errors == 0) $display("[sent_edge_capture_batcher] OK");
    else $display("[sent_edge_capture_batcher] ERROR");
    $finish;
  end

endmodule
